[hdl/lru_page_replacement_macros.svh]
// ----------------------------------------------------------------------------
// lru_page_replacement assertion macros
// concurrent check wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

`ifndef ASSERT_OFF
`define LRUPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LRUPR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define LRUPR_ASSERT(lbl, prop, msg)
`define LRUPR_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[hdl/lrupr_pkg.sv]
// ----------------------------------------------------------------------------
// lrupr_pkg
// shared sizes, outcome codes and result type of the lru page store
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int PAGE_W      = 16;
  localparam int CFG_W       = 4;
  localparam int CFG_RESET   = 8;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int REC_W = IDX_W;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic [1:0] {
    OUT_HIT     = 2'd0,
    OUT_FILL    = 2'd1,
    OUT_REPLACE = 2'd2
  } outcome_e;

  typedef struct packed {
    outcome_e            outcome;
    logic [PAGE_W-1:0]   evicted;
  } lrupr_res_t;

endpackage

[hdl/lrupr_slots.sv]
// ----------------------------------------------------------------------------
// lrupr_slots
// page slots with ages: parallel tag compare, victim pick and age update
// ----------------------------------------------------------------------------
module lrupr_slots
  import lrupr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              upd_i,
  input  logic [PAGE_W-1:0] page_i,
  input  logic [CFG_W-1:0]  active_i,
  output lrupr_res_t        res_o
);

  logic [PAGE_W-1:0] page_q [MAX_ENTRIES];
  logic [PAGE_W-1:0] page_d [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [REC_W-1:0]  rec_q [MAX_ENTRIES];
  logic [REC_W-1:0]  rec_d [MAX_ENTRIES];
  logic [CNT_W-1:0]  filled_q, filled_d;

  logic [MAX_ENTRIES-1:0] hit_vec, old_vec;
  logic              hit, fill;
  logic [IDX_W-1:0]  hit_idx, free_idx, vic_idx, tgt_idx;
  logic [REC_W-1:0]  hit_rec, vic_age;
  logic [CAP_W-1:0]  act_ext, cap;

  // capacity clamp
  always_comb begin
    act_ext = CAP_W'(active_i);
    if (act_ext == '0) begin
      cap = CAP_W'(1);
    end else if (act_ext > CAP_W'(MAX_ENTRIES)) begin
      cap = CAP_W'(MAX_ENTRIES);
    end else begin
      cap = act_ext;
    end
  end

  // ages of valid slots are always 0..filled-1, so the oldest is filled-1
  assign vic_age = REC_W'(filled_q - CNT_W'(1));

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i] = valid_q[i] && (page_q[i] == page_i);
      old_vec[i] = valid_q[i] && (rec_q[i] == vic_age);
    end
    hit_idx  = '0;
    free_idx = '0;
    vic_idx  = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = IDX_W'(i);
      if (!valid_q[i]) free_idx = IDX_W'(i);
      if (old_vec[i]) vic_idx = IDX_W'(i);
    end
    hit     = |hit_vec;
    hit_rec = rec_q[hit_idx];
    fill    = !hit && (CAP_W'(filled_q) < cap) && !(&valid_q);
    tgt_idx = hit ? hit_idx : (fill ? free_idx : vic_idx);
  end

  always_comb begin
    if (hit) begin
      res_o.outcome = OUT_HIT;
      res_o.evicted = '0;
    end else if (fill) begin
      res_o.outcome = OUT_FILL;
      res_o.evicted = '0;
    end else begin
      res_o.outcome = OUT_REPLACE;
      res_o.evicted = page_q[vic_idx];
    end
  end

  always_comb begin
    valid_d  = valid_q;
    filled_d = filled_q;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      page_d[i] = page_q[i];
      rec_d[i]  = rec_q[i];
    end
    if (upd_i) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (IDX_W'(i) == tgt_idx) begin
          rec_d[i]   = '0;
          page_d[i]  = page_i;
          valid_d[i] = 1'b1;
        end else if (valid_q[i] && (!hit || rec_q[i] < hit_rec)) begin
          rec_d[i] = rec_q[i] + REC_W'(1);
        end
      end
      if (fill) begin
        filled_d = filled_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      filled_q <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rec_q[i] <= '0;
      end
    end else begin
      valid_q  <= valid_d;
      filled_q <= filled_d;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rec_q[i] <= rec_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      page_q[i] <= page_d[i];
    end
  end

endmodule

[hdl/lru_page_replacement.sv]
// ----------------------------------------------------------------------------
// lru_page_replacement
// path: input beat held in the input reg, its result then held in the result reg
// throughput: one access per cycle while the result stream is not stalled
// reset: all slots invalid, no pages resident, capacity register at 8
// fully associative lru page store with stream ports and a capacity register
// ----------------------------------------------------------------------------
`include "lru_page_replacement_macros.svh"

module lru_page_replacement
  import lrupr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_W-1:0]  cfg_data_i,    // active_entries
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,  // page_number
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata   // outcome, evicted_page, zero pad
);

  logic [CFG_W-1:0]  active_q;
  logic              in_vld_q, in_vld_d;
  logic [PAGE_W-1:0] in_page_q;
  logic              out_vld_q, out_vld_d;
  lrupr_res_t        out_res_q, res;
  logic              advance, s_fire, m_fire;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = out_vld_q && m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_res_q.evicted, out_res_q.outcome};

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_fire) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (m_fire) begin
      out_vld_d = 1'b0;
    end
  end

  lrupr_slots u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (advance),
    .page_i   (in_page_q),
    .active_i (active_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= CFG_W'(CFG_RESET);
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) active_q <= cfg_data_i;
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) in_page_q <= s_axis_tdata[PAGE_W-1:0];
    if (advance) out_res_q <= res;
  end

  `LRUPR_ASSERT(a_adv_result, advance |=> out_vld_q, "advanced item has no result beat")
  `LRUPR_ASSERT(a_held_item, (in_vld_q && !advance) |=> (in_vld_q && $stable(in_page_q)), "waiting item lost")
  `LRUPR_ASSERT_NEVER(a_evict_zero, out_vld_q && out_res_q.outcome != OUT_REPLACE && out_res_q.evicted != '0, "evicted page set without replacement")

endmodule

[tb/sv/lru_outcome_board.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_outcome_board
// tracks the resident pages, their ages and the capacity register, works out
// the outcome and evicted page of every accepted access beat and checks each
// result beat of the lru page store against the oldest one still due
// ----------------------------------------------------------------------------
class lru_outcome_board;

  logic [lrupr_pkg::PAGE_W-1:0] res_page [lrupr_pkg::MAX_ENTRIES];
  bit                           res_valid[lrupr_pkg::MAX_ENTRIES];
  int unsigned                  res_age  [lrupr_pkg::MAX_ENTRIES];
  int unsigned                  filled;
  logic [lrupr_pkg::CFG_W-1:0]  cap_reg;
  lrupr_pkg::lrupr_res_t        due_outcomes[$];
  int                           errors;

  function new();
    for (int i = 0; i < lrupr_pkg::MAX_ENTRIES; i++) begin
      res_page[i]  = '0;
      res_valid[i] = 1'b0;
      res_age[i]   = 0;
    end
    filled  = 0;
    cap_reg = (lrupr_pkg::CFG_W)'(lrupr_pkg::CFG_RESET);
    errors  = 0;
  endfunction

  function void set_capacity(logic [lrupr_pkg::CFG_W-1:0] v);
    cap_reg = v;
  endfunction

  function int pending();
    return due_outcomes.size();
  endfunction

  // age every valid slot younger than limit, slot s becomes newest
  function void make_newest(int s, int unsigned limit);
    for (int i = 0; i < lrupr_pkg::MAX_ENTRIES; i++)
      if (res_valid[i] && i != s && res_age[i] < limit) res_age[i]++;
    res_age[s] = 0;
  endfunction

  function void note_access(logic [lrupr_pkg::PAGE_W-1:0] page);
    lrupr_pkg::lrupr_res_t r;
    int unsigned cap;
    int          slot;
    int unsigned oldest;
    bit          found;
    cap = cap_reg;
    if (cap < 1) cap = 1;
    if (cap > lrupr_pkg::MAX_ENTRIES) cap = lrupr_pkg::MAX_ENTRIES;
    r.outcome = lrupr_pkg::OUT_HIT;
    r.evicted = '0;
    slot = -1;
    for (int i = 0; i < lrupr_pkg::MAX_ENTRIES; i++)
      if (slot < 0 && res_valid[i] && res_page[i] == page) slot = i;
    if (slot >= 0) begin
      make_newest(slot, res_age[slot]);
      due_outcomes.push_back(r);
      return;
    end
    if (filled < cap) begin
      for (int i = 0; i < lrupr_pkg::MAX_ENTRIES; i++)
        if (slot < 0 && !res_valid[i]) slot = i;
      if (slot >= 0) begin
        res_valid[slot] = 1'b1;
        res_page[slot]  = page;
        make_newest(slot, 32'hFFFF_FFFF);
        filled++;
        r.outcome = lrupr_pkg::OUT_FILL;
        due_outcomes.push_back(r);
        return;
      end
    end
    slot   = 0;
    oldest = 0;
    found  = 1'b0;
    for (int i = 0; i < lrupr_pkg::MAX_ENTRIES; i++) begin
      if (res_valid[i] && (!found || res_age[i] > oldest)) begin
        slot   = i;
        oldest = res_age[i];
        found  = 1'b1;
      end
    end
    r.outcome       = lrupr_pkg::OUT_REPLACE;
    r.evicted       = found ? res_page[slot] : '0;
    res_valid[slot] = 1'b1;
    res_page[slot]  = page;
    make_newest(slot, 32'hFFFF_FFFF);
    due_outcomes.push_back(r);
  endfunction

  function void check_outcome(logic [23:0] d);
    lrupr_pkg::lrupr_res_t e;
    if (due_outcomes.size() == 0) begin
      $display("%0t unexpected result beat: expected none, actual %h", $time, d);
      errors++;
      return;
    end
    e = due_outcomes.pop_front();
    if (d[1:0] != e.outcome) begin
      $display("%0t outcome mismatch: expected %0d, actual %0d", $time, e.outcome, d[1:0]);
      errors++;
    end
    if (d[17:2] != e.evicted) begin
      $display("%0t evicted page mismatch: expected %h, actual %h", $time, e.evicted,
               d[17:2]);
      errors++;
    end
    if (d[23:18] != '0) begin
      $display("%0t pad bits mismatch: expected 0, actual %h", $time, d[23:18]);
      errors++;
    end
  endfunction

endclass

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives page access beats into the lru page store under changing capacity
// settings and random stalls on both streams, and checks every result beat
// ----------------------------------------------------------------------------
module tb;
  import lrupr_pkg::*;

  localparam int NUM_PHASES      = 18;
  localparam int ITEMS_PER_PHASE = 105;
  localparam int CYCLE_LIMIT     = 400000;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_data_i    = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;

  lru_outcome_board board = new();

  int          recv_idle = 0;
  int          send_idle = 0;
  int          hold_left = 0;
  int          cycles    = 0;
  int unsigned cap_plan[NUM_PHASES] = '{1, 2, 8, 3, 0, 15, 5, 8, 1, 7, 9, 4, 8, 6, 12, 2, 8, 3};
  logic [15:0] directed[22] = '{
    16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA, 16'h1234, 16'h00FF,
    16'h0000, 16'hFFFF, 16'h7777, 16'h0001, 16'h00FF, 16'h5555,
    16'h4444, 16'h4445, 16'h5555, 16'h9999, 16'h9999, 16'h9998, 16'h1111, 16'h2222};

  lru_page_replacement i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL lru_page_replacement");
      $finish;
    end
  end

  // receiver, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_outcome(m_axis_tdata);
  end

  task automatic idle_cycles(input int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_page(input logic [15:0] page);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= page;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_access(page);
  endtask

  task automatic drain();
    idle_cycles(1);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] v);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.set_capacity(v);
  endtask

  task automatic send_with_gap(input logic [15:0] page);
    if ($urandom_range(99) < send_idle) idle_cycles($urandom_range(1, 4));
    send_page(page);
  endtask

  initial begin
    logic [15:0] pool[16];
    int          pool_size;
    logic [15:0] page;
    int          mode;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill, hits, replacement, then capacity below fill, zero and saturated
    for (int k = 0; k < 14; k++) send_page(directed[k]);
    write_capacity(4'd3);
    for (int k = 14; k < 17; k++) send_page(directed[k]);
    write_capacity(4'd0);
    for (int k = 17; k < 20; k++) send_page(directed[k]);
    write_capacity(4'd15);
    for (int k = 20; k < 22; k++) send_page(directed[k]);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      mode = (ph * 3) / NUM_PHASES;
      write_capacity(cap_plan[ph][CFG_W-1:0]);
      if (mode == 0) begin
        send_idle = 12;
        recv_idle = 85;
      end else if (mode == 1) begin
        send_idle = 85;
        recv_idle = 12;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      pool_size = $urandom_range(1, 12);
      for (int j = 0; j < pool_size; j++) pool[j] = 16'($urandom);
      case ($urandom_range(3))
        0: pool[0] = 16'h0000;
        1: pool[0] = 16'hFFFF;
        default: ;
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == 50) begin
          if (ph % 2 == 0) hold_left = 120;
          else drain();
        end
        if ($urandom_range(99) < 80) page = pool[$urandom_range(pool_size - 1)];
        else page = 16'($urandom);
        send_with_gap(page);
      end
    end

    drain();
    repeat (12) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS lru_page_replacement");
    end else begin
      $display("FAIL lru_page_replacement");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/lrupr_pkg.sv
hdl/lrupr_slots.sv
hdl/lru_page_replacement.sv
tb/sv/lru_outcome_board.sv
tb/sv/tb.sv
